// File: rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths and types of the UTF-8 decoder with raw-byte fallback.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 21;
  localparam int MAX_RES = 4;                    // results one byte may cause
  localparam int SLOT_W  = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int QDEPTH  = 2;                    // job queue entries
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One classified byte: how many results it gives and their values.
  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    logic [MAX_RES-1:0][CODE_W-1:0]  vals;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/utf8d_byte_if.sv
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Byte channel: one text byte per transfer, with an end-of-string flag.
// ----------------------------------------------------------------------------
interface utf8d_byte_if import utf8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              end_of_text;

  modport source (output valid, byte_in, end_of_text, input ready);
  modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

// File: rtl/utf8d_code_if.sv
// ----------------------------------------------------------------------------
// utf8d_code_if
// Code channel: one code point or raw byte value per transfer.
// ----------------------------------------------------------------------------
interface utf8d_code_if import utf8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_value;
  logic              last_of_run;

  modport source (output valid, code_value, last_of_run, input ready);
  modport sink   (input valid, code_value, last_of_run, output ready);
endinterface

// File: rtl/utf8_decoder_raw_fallback_unit.sv
// Results: a byte's job is registered in the job queue and offered from its head.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the result port is ready; a byte that gives k results holds the port for
//   k transfers, and the two-entry job queue sets how far input runs ahead.
// Reset: synchronous, active low; clears the sequence tracker, the queue and
//   the result index. Held continuation bytes keep no reset value.
// ----------------------------------------------------------------------------
// utf8_decoder_raw_fallback_unit
// UTF-8 decoder that gives broken sequences back as raw byte values.
// ----------------------------------------------------------------------------
module utf8_decoder_raw_fallback_unit import utf8d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  utf8d_byte_if.sink   in_ch,
  utf8d_code_if.source out_ch
);

  // Front end: the tracker takes a byte whenever the queue has a free entry,
  // independent of the result side; a waiting result stalls input only once
  // both queue entries hold jobs.
  logic   in_acc;
  push_t  push;
  job_t   head;
  qstat_t qstat;
  logic   pop;

  assign in_ch.ready = !qstat.full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  utf8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .byte_in     (in_ch.byte_in),
    .end_of_text (in_ch.end_of_text),
    .push        (push)
  );

  // Queue: holds classified jobs; bytes that only open or extend a sequence
  // push nothing.
  utf8d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (qstat)
  );

  // Back end: hand out the head job's values in order, flag the last one and
  // release the entry on its transfer.
  utf8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!qstat.empty),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_code   (out_ch.code_value),
    .out_last   (out_ch.last_of_run),
    .pop        (pop)
  );

  // Every pushed job carries between one and the maximum number of results.
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (push.job.cnt != '0 && push.job.cnt <= CNT_W'(MAX_RES)))
    else $error("job with bad result count");

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full)
    else $error("push into full queue");

  // An entry is released only on the transfer of its last result.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (out_ch.valid && out_ch.ready && out_ch.last_of_run))
    else $error("queue entry released early");

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered after reset");

endmodule

// File: rtl/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Sequence tracker: classifies each accepted byte and builds its result job.
// ----------------------------------------------------------------------------
module utf8d_front import utf8d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              end_of_text,
  output push_t             push
);

  logic [BYTE_W-1:0] lead_r,    lead_nxt;
  logic [CODE_W-1:0] partial_r, partial_nxt;
  logic [1:0]        need_r,    need_nxt;
  logic [1:0]        seen_r,    seen_nxt;
  logic [BYTE_W-1:0] held_r [2];
  logic              held_we;

  logic              is_cont;
  logic              sb_lead;
  logic [1:0]        sb_extra;
  logic [CODE_W-1:0] sb_bits;
  logic              sb_emit;
  logic              sb_open;
  logic [CODE_W-1:0] byte_ext;
  logic [CODE_W-1:0] acc_val;
  logic [2:0]        seen_p1;
  logic [SLOT_W-1:0] tail_idx;
  job_t              job;

  // Classify the byte as a fresh start.
  always_comb begin
    sb_lead  = 1'b1;
    sb_extra = 2'd0;
    sb_bits  = '0;
    if (byte_in[7] == 1'b0) begin
      sb_lead = 1'b0;
    end else if (byte_in[7:5] == 3'b110) begin
      sb_extra = 2'd1;
      sb_bits  = {{(CODE_W-5){1'b0}}, byte_in[4:0]};
    end else if (byte_in[7:4] == 4'b1110) begin
      sb_extra = 2'd2;
      sb_bits  = {{(CODE_W-4){1'b0}}, byte_in[3:0]};
    end else if (byte_in[7:3] == 5'b11110) begin
      sb_extra = 2'd3;
      sb_bits  = {{(CODE_W-3){1'b0}}, byte_in[2:0]};
    end else begin
      sb_lead = 1'b0;
    end
    sb_open = sb_lead && !end_of_text;
    sb_emit = !sb_open;
  end

  assign is_cont  = (byte_in[7:6] == 2'b10);
  assign byte_ext = {{(CODE_W-BYTE_W){1'b0}}, byte_in};
  assign acc_val  = {partial_r[CODE_W-7:0], byte_in[5:0]};
  assign seen_p1  = {1'b0, seen_r} + 3'd1;
  assign tail_idx = SLOT_W'(seen_p1);

  always_comb begin
    lead_nxt    = lead_r;
    partial_nxt = partial_r;
    need_nxt    = need_r;
    seen_nxt    = seen_r;
    held_we     = 1'b0;
    job.cnt     = '0;
    job.vals[0] = {{(CODE_W-BYTE_W){1'b0}}, lead_r};
    job.vals[1] = {{(CODE_W-BYTE_W){1'b0}}, held_r[0]};
    job.vals[2] = {{(CODE_W-BYTE_W){1'b0}}, held_r[1]};
    job.vals[3] = '0;

    if (need_r != 2'd0 && is_cont) begin
      if (seen_p1 >= {1'b0, need_r}) begin
        job.cnt     = CNT_W'(1);
        job.vals[0] = acc_val;
        need_nxt    = 2'd0;
        seen_nxt    = 2'd0;
        partial_nxt = '0;
      end else if (end_of_text) begin
        // drop the open sequence: lead, held bytes, this byte, all raw
        job.vals[tail_idx] = byte_ext;
        job.cnt     = CNT_W'({1'b0, tail_idx}) + CNT_W'(1);
        need_nxt    = 2'd0;
        seen_nxt    = 2'd0;
        partial_nxt = '0;
      end else begin
        partial_nxt = acc_val;
        held_we     = 1'b1;
        seen_nxt    = seen_r + 2'd1;
      end
    end else begin
      if (need_r != 2'd0) begin
        // broken sequence: flush raw, then restart on this byte
        need_nxt    = 2'd0;
        seen_nxt    = 2'd0;
        partial_nxt = '0;
        job.cnt     = CNT_W'({1'b0, tail_idx});
        if (sb_emit) begin
          job.vals[tail_idx] = byte_ext;
          job.cnt            = CNT_W'({1'b0, tail_idx}) + CNT_W'(1);
        end
      end else if (sb_emit) begin
        job.cnt     = CNT_W'(1);
        job.vals[0] = byte_ext;
      end
      if (sb_open) begin
        lead_nxt    = byte_in;
        partial_nxt = sb_bits;
        need_nxt    = sb_extra;
        seen_nxt    = 2'd0;
      end
    end
  end

  assign push.valid = acc && (job.cnt != '0);
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= '0;
      partial_r <= '0;
      need_r    <= 2'd0;
      seen_r    <= 2'd0;
    end else if (acc) begin
      lead_r    <= lead_nxt;
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      seen_r    <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && held_we) begin
      held_r[seen_r[0]] <= byte_in;
    end
  end

endmodule

// File: rtl/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Two-entry job queue between the tracker and the result sequencer.
// ----------------------------------------------------------------------------
module utf8d_queue import utf8d_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output job_t   head,
  output qstat_t stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = push.valid ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push.valid) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_r] <= push.job;
    end
  end

  assign head       = mem_r[rd_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// File: rtl/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Result sequencer: steps through the head job, one result per transfer.
// ----------------------------------------------------------------------------
module utf8d_back import utf8d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              head,
  input  logic              head_valid,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last,
  output logic              pop
);

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              xfer;

  assign out_valid = head_valid;
  assign out_code  = head.vals[idx_r];
  assign out_last  = (CNT_W'({1'b0, idx_r}) + CNT_W'(1)) == head.cnt;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = out_last ? '0 : idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
